### design/assert_macros.svh
// assertion helpers for the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every rising clk edge, muted while rst is high
`define MVA_ASSERT(lbl, prop, txt) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(txt);

// property checked on every rising clk edge, reset included
`define MVA_ASSERT_ALWAYS(lbl, prop, txt) \
  lbl: assert property (@(posedge clk) prop) else $error(txt);

`endif

### design/mva_pkg.sv
// ----------------------------------------------------------------------------
// mva_pkg
// Shared types, codes and helpers of the MIDI voice allocator.
// ----------------------------------------------------------------------------
`default_nettype none

package mva_pkg;

  localparam int VOICES  = 16;
  localparam int VW      = $clog2(VOICES);
  localparam int MAX_RES = 32;
  localparam int RW      = $clog2(MAX_RES + 1);

  localparam logic [15:0] VEL_SCALE = 16'd51603;

  // configuration register indexes
  localparam logic [2:0] CFG_MONO      = 3'd0;
  localparam logic [2:0] CFG_NORM_VEL  = 3'd1;
  localparam logic [2:0] CFG_MPE       = 3'd2;
  localparam logic [2:0] CFG_TRANSPOSE = 3'd3;
  localparam logic [2:0] CFG_OSC_SYNC  = 3'd4;

  // message types (status high nibble)
  localparam logic [3:0] REQ_NOTE_OFF = 4'h8;
  localparam logic [3:0] REQ_NOTE_ON  = 4'h9;
  localparam logic [3:0] REQ_CC       = 4'hB;
  localparam logic [3:0] REQ_PROGRAM  = 4'hC;
  localparam logic [3:0] REQ_PRESSURE = 4'hD;
  localparam logic [3:0] REQ_BEND     = 4'hE;

  // controller numbers
  localparam logic [6:0] CC_MOD     = 7'd1;
  localparam logic [6:0] CC_BREATH  = 7'd2;
  localparam logic [6:0] CC_FOOT    = 7'd4;
  localparam logic [6:0] CC_TIMBRE  = 7'd74;
  localparam logic [6:0] CC_SUSTAIN = 7'd64;
  localparam logic [6:0] CC_ALL_OFF = 7'd123;
  localparam logic [6:0] PEDAL_THR  = 7'd63;
  localparam logic [6:0] PROG_MAX   = 7'd31;
  localparam logic [3:0] MPE_MASTER = 4'd1;

  // result commands
  localparam logic [3:0] CMD_START      = 4'd0;
  localparam logic [3:0] CMD_RELEASE    = 4'd1;
  localparam logic [3:0] CMD_XFER_SIG   = 4'd2;
  localparam logic [3:0] CMD_XFER_STATE = 4'd3;
  localparam logic [3:0] CMD_TIMBRE     = 4'd4;
  localparam logic [3:0] CMD_PRESSURE   = 4'd5;
  localparam logic [3:0] CMD_VOICE_BEND = 4'd6;
  localparam logic [3:0] CMD_CONTROLLER = 4'd7;
  localparam logic [3:0] CMD_PROGRAM    = 4'd8;

  // controller ids
  localparam logic [2:0] CTL_MOD        = 3'd0;
  localparam logic [2:0] CTL_BREATH     = 3'd1;
  localparam logic [2:0] CTL_FOOT       = 3'd2;
  localparam logic [2:0] CTL_AFTERTOUCH = 3'd3;
  localparam logic [2:0] CTL_BEND       = 3'd4;

  typedef struct packed {
    logic [7:0] status_byte;
    logic [6:0] first_data;
    logic [6:0] second_data;
  } msg_t;

  typedef struct packed {
    logic [3:0]  command;
    logic [3:0]  voice_index;
    logic [3:0]  source_voice;
    logic [7:0]  note_number;
    logic [6:0]  velocity;
    logic        osc_sync;
    logic [2:0]  controller_id;
    logic [13:0] value;
    logic        last;
  } res_t;

  // message class, settled when the item is taken
  typedef enum logic [2:0] {
    CLS_NONE,
    CLS_SINGLE,
    CLS_EXPR,
    CLS_KEYUP,
    CLS_KEYDOWN,
    CLS_PEDAL_OFF,
    CLS_ALL_OFF
  } msg_cls_t;

  // datapath operations issued by the controller
  typedef enum logic [3:0] {
    OP_NOP,
    OP_LOAD,
    OP_SINGLE,
    OP_EXPR,
    OP_UPSCAN,
    OP_DNSCAN,
    OP_DNWRITE,
    OP_MONO,
    OP_REL,
    OP_HIGH,
    OP_XFER,
    OP_RELEND,
    OP_ANO,
    OP_SUSOFF,
    OP_FINISH
  } dp_op_t;

  typedef struct packed {
    msg_cls_t cls;
    logic     hit;
    logic     last;
    logic     dn_found;
    logic     ano_last;
    logic     emit_ok;
    logic     mono;
  } dp_status_t;

  // round-robin successor of a voice index
  function automatic logic [VW-1:0] next_idx(input logic [VW-1:0] i);
    if (i == VW'(VOICES - 1)) begin
      return '0;
    end
    return i + VW'(1);
  endfunction

endpackage

`default_nettype wire

### design/mva_datapath.sv
// ----------------------------------------------------------------------------
// mva_datapath
// Voice table, message registers, scan counters and result buffering.
// ----------------------------------------------------------------------------
`default_nettype none

module mva_datapath (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire mva_pkg::msg_t           msg,
  input  wire logic                    cfg_valid,
  input  wire logic [2:0]              cfg_index,
  input  wire logic [5:0]              cfg_data,
  input  wire mva_pkg::dp_op_t         op,
  output mva_pkg::dp_status_t          status,
  output mva_pkg::res_t                res,
  output logic                         res_valid,
  input  wire logic                    res_ready
);

  localparam int VW = mva_pkg::VW;
  localparam int RW = mva_pkg::RW;

  // configuration
  logic       mono_mode;
  logic       norm_vel;
  logic       mpe_enable;
  logic       osc_sync_en;
  logic [5:0] shift;

  // global state
  logic [mva_pkg::VOICES-1:0] held;
  logic [mva_pkg::VOICES-1:0] sust;
  logic [mva_pkg::VOICES-1:0] live;
  logic [VW-1:0]              next_voice;
  logic                       pedal;
  logic                       fallback;

  // voice payload, one read port at sidx
  logic [3:0] chan_mem [mva_pkg::VOICES];
  logic [7:0] note_mem [mva_pkg::VOICES];

  // message registers
  logic [3:0]        chan;
  logic [3:0]        req;
  logic [6:0]        d1;
  logic [6:0]        d2;
  logic [7:0]        pitch;
  logic [6:0]        vel;
  logic              mpe_q;
  mva_pkg::msg_cls_t cls;

  // scan registers
  logic [VW-1:0] sidx;
  logic [VW-1:0] cnt;
  logic [VW-1:0] found;
  logic          found_v;
  logic [VW-1:0] oidx;
  logic [VW-1:0] rv;
  logic [VW-1:0] target;
  logic [7:0]    high;
  logic          high_v;

  // result buffering
  mva_pkg::res_t pend;
  logic          pend_v;
  mva_pkg::res_t out_q;
  logic          out_v;
  logic [RW-1:0] rcount;

  // combinational helpers
  logic [3:0]        in_chan;
  logic [3:0]        in_req;
  logic              in_mpe;
  mva_pkg::msg_cls_t in_cls;
  logic [7:0]        in_pitch;
  logic [22:0]       vel_prod;
  logic [3:0]        ch;
  logic [7:0]        nt;
  logic              held_s;
  logic              em;
  mva_pkg::res_t     em_res;
  logic              hit;
  logic              last;
  logic              emit_ok;
  logic              scan_step;
  logic              push;
  logic              flush;
  mva_pkg::res_t     fin_res;

  assign in_chan  = msg.status_byte[3:0];
  assign in_req   = msg.status_byte[7:4];
  assign in_mpe   = mpe_enable && !fallback;
  assign in_pitch = {1'b0, msg.first_data} + {{2{shift[5]}}, shift};
  assign vel_prod = 23'(msg.second_data) * 23'(mva_pkg::VEL_SCALE);

  assign ch      = chan_mem[sidx];
  assign nt      = note_mem[sidx];
  assign held_s  = held[sidx];
  assign last    = (cnt == VW'(mva_pkg::VOICES - 1));
  assign emit_ok = !pend_v || !out_v || res_ready;

  // message classification
  always_comb begin
    in_cls = mva_pkg::CLS_NONE;
    if (in_mpe && in_chan != mva_pkg::MPE_MASTER &&
        ((in_req == mva_pkg::REQ_CC && msg.first_data == mva_pkg::CC_TIMBRE) ||
         in_req == mva_pkg::REQ_PRESSURE || in_req == mva_pkg::REQ_BEND)) begin
      in_cls = mva_pkg::CLS_EXPR;
    end else begin
      case (in_req)
        mva_pkg::REQ_NOTE_OFF: in_cls = mva_pkg::CLS_KEYUP;
        mva_pkg::REQ_NOTE_ON: begin
          in_cls = (msg.second_data == 7'd0) ? mva_pkg::CLS_KEYUP : mva_pkg::CLS_KEYDOWN;
        end
        mva_pkg::REQ_CC: begin
          if (msg.first_data == mva_pkg::CC_MOD || msg.first_data == mva_pkg::CC_BREATH ||
              msg.first_data == mva_pkg::CC_FOOT) begin
            in_cls = mva_pkg::CLS_SINGLE;
          end else if (msg.first_data == mva_pkg::CC_SUSTAIN) begin
            in_cls = (msg.second_data > mva_pkg::PEDAL_THR) ? mva_pkg::CLS_NONE
                                                            : mva_pkg::CLS_PEDAL_OFF;
          end else if (msg.first_data == mva_pkg::CC_ALL_OFF) begin
            in_cls = mva_pkg::CLS_ALL_OFF;
          end
        end
        mva_pkg::REQ_PROGRAM, mva_pkg::REQ_PRESSURE, mva_pkg::REQ_BEND: begin
          in_cls = mva_pkg::CLS_SINGLE;
        end
        default: in_cls = mva_pkg::CLS_NONE;
      endcase
    end
  end

  // result produced by the current operation
  always_comb begin
    em     = 1'b0;
    em_res = '0;
    case (op)
      mva_pkg::OP_SINGLE: begin
        em = 1'b1;
        em_res.command = mva_pkg::CMD_CONTROLLER;
        case (req)
          mva_pkg::REQ_CC: begin
            em_res.value = {7'd0, d2};
            if (d1 == mva_pkg::CC_BREATH) begin
              em_res.controller_id = mva_pkg::CTL_BREATH;
            end else if (d1 == mva_pkg::CC_FOOT) begin
              em_res.controller_id = mva_pkg::CTL_FOOT;
            end else begin
              em_res.controller_id = mva_pkg::CTL_MOD;
            end
          end
          mva_pkg::REQ_PROGRAM: begin
            em_res.command = mva_pkg::CMD_PROGRAM;
            em_res.value   = {7'd0, (d1 > mva_pkg::PROG_MAX) ? mva_pkg::PROG_MAX : d1};
          end
          mva_pkg::REQ_PRESSURE: begin
            em_res.controller_id = mva_pkg::CTL_AFTERTOUCH;
            em_res.value         = {7'd0, d1};
          end
          default: begin
            em_res.controller_id = mva_pkg::CTL_BEND;
            em_res.value         = {d2, d1};
          end
        endcase
      end
      mva_pkg::OP_EXPR: begin
        em = held_s && (ch == chan);
        em_res.voice_index = 4'(sidx);
        case (req)
          mva_pkg::REQ_CC: begin
            em_res.command = mva_pkg::CMD_TIMBRE;
            em_res.value   = {7'd0, d2};
          end
          mva_pkg::REQ_PRESSURE: begin
            em_res.command = mva_pkg::CMD_PRESSURE;
            em_res.value   = {7'd0, d1};
          end
          default: begin
            em_res.command = mva_pkg::CMD_VOICE_BEND;
            em_res.value   = {d2, d1};
          end
        endcase
      end
      mva_pkg::OP_DNWRITE: begin
        em = 1'b1;
        em_res.command     = mva_pkg::CMD_START;
        em_res.voice_index = 4'(found);
        em_res.note_number = pitch;
        em_res.velocity    = vel;
        em_res.osc_sync    = osc_sync_en;
      end
      mva_pkg::OP_MONO: begin
        em = live[sidx] && (!held_s || nt < pitch);
        em_res.command      = held_s ? mva_pkg::CMD_XFER_STATE : mva_pkg::CMD_XFER_SIG;
        em_res.voice_index  = 4'(found);
        em_res.source_voice = 4'(sidx);
      end
      mva_pkg::OP_XFER: begin
        em = high_v && live[rv];
        em_res.command      = mva_pkg::CMD_XFER_STATE;
        em_res.voice_index  = 4'(target);
        em_res.source_voice = 4'(rv);
      end
      mva_pkg::OP_RELEND: begin
        em = !pedal;
        em_res.command     = mva_pkg::CMD_RELEASE;
        em_res.voice_index = 4'(rv);
      end
      mva_pkg::OP_SUSOFF: begin
        em = sust[sidx] && !held_s;
        em_res.command     = mva_pkg::CMD_RELEASE;
        em_res.voice_index = 4'(sidx);
      end
      default: em = 1'b0;
    endcase
  end

  // per-operation condition for the controller
  always_comb begin
    case (op)
      mva_pkg::OP_EXPR:   hit = held_s && (ch == chan);
      mva_pkg::OP_UPSCAN: hit = held_s && (mpe_q ? (ch == chan) : (nt == pitch));
      mva_pkg::OP_MONO:   hit = live[sidx];
      mva_pkg::OP_ANO:    hit = held[oidx];
      default:            hit = 1'b0;
    endcase
  end

  always_comb begin
    case (op)
      mva_pkg::OP_EXPR, mva_pkg::OP_UPSCAN, mva_pkg::OP_DNSCAN, mva_pkg::OP_MONO,
      mva_pkg::OP_HIGH, mva_pkg::OP_SUSOFF: scan_step = 1'b1;
      default: scan_step = 1'b0;
    endcase
  end

  assign status.cls      = cls;
  assign status.hit      = hit;
  assign status.last     = last;
  assign status.dn_found = found_v || !held_s;
  assign status.ano_last = (oidx == VW'(mva_pkg::VOICES - 1));
  assign status.emit_ok  = emit_ok;
  assign status.mono     = mono_mode;

  // message registers, latched with the item
  always_ff @(posedge clk) begin
    if (op == mva_pkg::OP_LOAD) begin
      chan  <= in_chan;
      req   <= in_req;
      d1    <= msg.first_data;
      d2    <= msg.second_data;
      pitch <= in_pitch;
      vel   <= norm_vel ? vel_prod[22:16] : msg.second_data;
      mpe_q <= in_mpe;
    end
  end

  // voice payload store
  always_ff @(posedge clk) begin
    if (op == mva_pkg::OP_DNWRITE) begin
      chan_mem[found] <= chan;
      note_mem[found] <= pitch;
    end
  end

  // scan registers
  always_ff @(posedge clk) begin
    if (scan_step) begin
      sidx <= mva_pkg::next_idx(sidx);
      cnt  <= cnt + VW'(1);
    end
    case (op)
      mva_pkg::OP_LOAD: begin
        sidx <= (in_cls == mva_pkg::CLS_KEYDOWN) ? next_voice : '0;
        cnt  <= '0;
        oidx <= '0;
      end
      mva_pkg::OP_UPSCAN: if (hit) rv <= sidx;
      mva_pkg::OP_DNSCAN: begin
        if (!held_s && !found_v) found <= sidx;
      end
      mva_pkg::OP_DNWRITE, mva_pkg::OP_REL: begin
        sidx <= '0;
        cnt  <= '0;
      end
      mva_pkg::OP_HIGH: begin
        if (held_s && (!high_v || nt > high)) begin
          high   <= nt;
          target <= sidx;
        end
      end
      mva_pkg::OP_ANO: begin
        if (hit) rv <= oidx;
        else oidx <= mva_pkg::next_idx(oidx);
      end
      mva_pkg::OP_RELEND: oidx <= mva_pkg::next_idx(oidx);
      default: ;
    endcase
  end

  // control state: flags, configuration, class
  always_ff @(posedge clk) begin
    if (rst) begin
      held        <= '0;
      sust        <= '0;
      live        <= '0;
      next_voice  <= '0;
      pedal       <= 1'b0;
      fallback    <= 1'b0;
      mono_mode   <= 1'b0;
      norm_vel    <= 1'b0;
      mpe_enable  <= 1'b0;
      osc_sync_en <= 1'b0;
      shift       <= '0;
      cls         <= mva_pkg::CLS_NONE;
      found_v     <= 1'b0;
      high_v      <= 1'b0;
    end else begin
      case (op)
        mva_pkg::OP_LOAD: begin
          cls     <= in_cls;
          found_v <= 1'b0;
          if (in_cls != mva_pkg::CLS_EXPR && in_req == mva_pkg::REQ_CC &&
              msg.first_data == mva_pkg::CC_SUSTAIN) begin
            pedal <= msg.second_data > mva_pkg::PEDAL_THR;
          end
        end
        mva_pkg::OP_DNSCAN: begin
          if (mpe_q && held_s && ch == chan) fallback <= 1'b1;
          if (!held_s) found_v <= 1'b1;
        end
        mva_pkg::OP_DNWRITE: begin
          held[found] <= 1'b1;
          sust[found] <= pedal;
          next_voice  <= mva_pkg::next_idx(found);
          if (!mono_mode) live[found] <= 1'b1;
        end
        mva_pkg::OP_MONO: begin
          if (em) begin
            live[sidx]  <= 1'b0;
            live[found] <= 1'b1;
          end else if (!hit && last) begin
            live[found] <= 1'b1;
          end
        end
        mva_pkg::OP_REL: begin
          held[rv] <= 1'b0;
          high_v   <= 1'b0;
        end
        mva_pkg::OP_HIGH: if (held_s) high_v <= 1'b1;
        mva_pkg::OP_XFER: begin
          if (em) begin
            live[rv]     <= 1'b0;
            live[target] <= 1'b1;
          end
        end
        mva_pkg::OP_RELEND: if (pedal) sust[rv] <= 1'b1;
        mva_pkg::OP_SUSOFF: if (em) sust[sidx] <= 1'b0;
        default: ;
      endcase
      // configuration writes arrive only while idle
      if (cfg_valid) begin
        case (cfg_index)
          mva_pkg::CFG_MONO:     mono_mode <= cfg_data[0];
          mva_pkg::CFG_NORM_VEL: norm_vel  <= cfg_data[0];
          mva_pkg::CFG_MPE: begin
            mpe_enable <= cfg_data[0];
            fallback   <= 1'b0;
          end
          mva_pkg::CFG_TRANSPOSE: shift       <= cfg_data;
          mva_pkg::CFG_OSC_SYNC:  osc_sync_en <= cfg_data[0];
          default: ;
        endcase
      end
    end
  end

  // result buffering: one pending item, one output register
  assign push  = em && (rcount < RW'(mva_pkg::MAX_RES));
  assign flush = (op == mva_pkg::OP_FINISH) && pend_v;

  // final item of a message carries the last mark
  always_comb begin
    fin_res      = pend;
    fin_res.last = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pend_v <= 1'b0;
      out_v  <= 1'b0;
      rcount <= '0;
    end else begin
      if (op == mva_pkg::OP_LOAD) begin
        rcount <= '0;
      end else if (push) begin
        rcount <= rcount + RW'(1);
      end
      if (push) begin
        pend   <= em_res;
        pend_v <= 1'b1;
      end else if (flush) begin
        pend_v <= 1'b0;
      end
      if (push && pend_v) begin
        out_q <= pend;
        out_v <= 1'b1;
      end else if (flush) begin
        out_q <= fin_res;
        out_v <= 1'b1;
      end else if (out_v && res_ready) begin
        out_v <= 1'b0;
      end
    end
  end

  assign res       = out_q;
  assign res_valid = out_v;

endmodule

`default_nettype wire

### design/mva_ctrl.sv
// ----------------------------------------------------------------------------
// mva_ctrl
// Sequencer that walks each message through its voice table scans.
// ----------------------------------------------------------------------------
`default_nettype none

module mva_ctrl (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                msg_valid,
  output logic                     msg_ready,
  input  wire mva_pkg::dp_status_t status,
  output mva_pkg::dp_op_t          op
);

  typedef enum logic [14:0] {
    S_IDLE     = 15'b000000000000001,
    S_DISPATCH = 15'b000000000000010,
    S_SINGLE   = 15'b000000000000100,
    S_EXPR     = 15'b000000000001000,
    S_UPSCAN   = 15'b000000000010000,
    S_DNSCAN   = 15'b000000000100000,
    S_DNWRITE  = 15'b000000001000000,
    S_MONO     = 15'b000000010000000,
    S_REL      = 15'b000000100000000,
    S_HIGH     = 15'b000001000000000,
    S_XFER     = 15'b000010000000000,
    S_RELEND   = 15'b000100000000000,
    S_ANO      = 15'b001000000000000,
    S_SUSOFF   = 15'b010000000000000,
    S_FINISH   = 15'b100000000000000
  } state_t;

  state_t state;
  state_t state_next;
  logic   go;

  assign msg_ready = (state == S_IDLE) && !rst;
  // any step may push a result, so all work waits for room downstream
  assign go = status.emit_ok;

  // operation issued in each state
  always_comb begin
    op = mva_pkg::OP_NOP;
    case (state)
      S_IDLE:    op = msg_valid ? mva_pkg::OP_LOAD : mva_pkg::OP_NOP;
      S_SINGLE:  op = mva_pkg::OP_SINGLE;
      S_EXPR:    op = mva_pkg::OP_EXPR;
      S_UPSCAN:  op = mva_pkg::OP_UPSCAN;
      S_DNSCAN:  op = mva_pkg::OP_DNSCAN;
      S_DNWRITE: op = mva_pkg::OP_DNWRITE;
      S_MONO:    op = mva_pkg::OP_MONO;
      S_REL:     op = mva_pkg::OP_REL;
      S_HIGH:    op = mva_pkg::OP_HIGH;
      S_XFER:    op = mva_pkg::OP_XFER;
      S_RELEND:  op = mva_pkg::OP_RELEND;
      S_ANO:     op = mva_pkg::OP_ANO;
      S_SUSOFF:  op = mva_pkg::OP_SUSOFF;
      S_FINISH:  op = mva_pkg::OP_FINISH;
      default:   op = mva_pkg::OP_NOP;
    endcase
    if (state != S_IDLE && !go) op = mva_pkg::OP_NOP;
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: if (msg_valid) state_next = S_DISPATCH;
      S_DISPATCH: begin
        case (status.cls)
          mva_pkg::CLS_SINGLE:    state_next = S_SINGLE;
          mva_pkg::CLS_EXPR:      state_next = S_EXPR;
          mva_pkg::CLS_KEYUP:     state_next = S_UPSCAN;
          mva_pkg::CLS_KEYDOWN:   state_next = S_DNSCAN;
          mva_pkg::CLS_PEDAL_OFF: state_next = S_SUSOFF;
          mva_pkg::CLS_ALL_OFF:   state_next = S_ANO;
          default:                state_next = S_FINISH;
        endcase
      end
      S_SINGLE: state_next = S_FINISH;
      S_EXPR: if (status.hit || status.last) state_next = S_FINISH;
      S_UPSCAN: begin
        if (status.hit) state_next = S_REL;
        else if (status.last) state_next = S_FINISH;
      end
      S_DNSCAN: begin
        if (status.last) state_next = status.dn_found ? S_DNWRITE : S_FINISH;
      end
      S_DNWRITE: state_next = status.mono ? S_MONO : S_FINISH;
      S_MONO: if (status.hit || status.last) state_next = S_FINISH;
      S_REL: state_next = status.mono ? S_HIGH : S_RELEND;
      S_HIGH: if (status.last) state_next = S_XFER;
      S_XFER: state_next = S_RELEND;
      S_RELEND: begin
        if (status.cls == mva_pkg::CLS_ALL_OFF && !status.ano_last) state_next = S_ANO;
        else state_next = S_FINISH;
      end
      S_ANO: begin
        if (status.hit) state_next = S_REL;
        else if (status.ano_last) state_next = S_FINISH;
      end
      S_SUSOFF: if (status.last) state_next = S_FINISH;
      S_FINISH: state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
    if (state != S_IDLE && !go) state_next = state;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

`default_nettype wire

### design/midi_voice_allocator.sv
// ----------------------------------------------------------------------------
// midi_voice_allocator
// Polyphonic round-robin voice allocator driven by three-byte MIDI messages.
//
//   channel  direction  handshake             payload
//   msg      in         msg_valid/msg_ready   mva_pkg::msg_t
//   res      out        res_valid/res_ready   mva_pkg::res_t
//   cfg      in         cfg_valid/cfg_ready   cfg_index (3), cfg_data (6)
//
// Controller and program messages give one result without a scan; a note-off
// scans for its voice and releases it, in mono mode after a highest-note scan;
// a note-on scans for a free voice, plus a handover scan in mono mode; and
// all-notes-off releases each held voice in turn. Reset is synchronous and
// needs no clearing pass. Scans take one voice per cycle on the single read
// port; all work pauses whenever a result cannot move to the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module midi_voice_allocator (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          msg_valid,
  output logic               msg_ready,
  input  wire mva_pkg::msg_t msg,
  output logic               res_valid,
  input  wire logic          res_ready,
  output mva_pkg::res_t      res,
  input  wire logic          cfg_valid,
  output logic               cfg_ready,
  input  wire logic [2:0]    cfg_index,
  input  wire logic [5:0]    cfg_data
);

  mva_pkg::dp_op_t     op;
  mva_pkg::dp_status_t status;

  // configuration is taken only between messages
  assign cfg_ready = msg_ready;

  mva_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .msg_valid (msg_valid),
    .msg_ready (msg_ready),
    .status    (status),
    .op        (op)
  );

  mva_datapath u_dp (
    .clk       (clk),
    .rst       (rst),
    .msg       (msg),
    .cfg_valid (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .op        (op),
    .status    (status),
    .res       (res),
    .res_valid (res_valid),
    .res_ready (res_ready)
  );

endmodule

`default_nettype wire

### design/mva_checker.sv
// ----------------------------------------------------------------------------
// mva_checker
// Port-level checks of the MIDI voice allocator, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module mva_checker (
  input wire logic          clk,
  input wire logic          rst,
  input wire logic          res_valid,
  input wire logic          res_ready,
  input wire mva_pkg::res_t res
);

  // a stalled item stays offered
  `MVA_ASSERT(a_res_hold, res_valid && !res_ready |=> res_valid, "res item dropped")

  // a stalled item keeps its payload
  `MVA_ASSERT(a_res_stable, res_valid && !res_ready |=> $stable(res), "res item changed")

  // nothing is offered right after reset
  `MVA_ASSERT_ALWAYS(a_reset_clear, rst |=> !res_valid, "res valid after reset")

  // only start items carry note, velocity and sync
  `MVA_ASSERT(a_start_fields, res_valid && res.command != mva_pkg::CMD_START |-> res.note_number == 8'd0 && res.velocity == 7'd0 && !res.osc_sync, "start fields on other item")

  // controller and program items address no voice
  `MVA_ASSERT(a_global_voice, res_valid && (res.command == mva_pkg::CMD_CONTROLLER || res.command == mva_pkg::CMD_PROGRAM) |-> res.voice_index == 4'd0 && res.source_voice == 4'd0, "voice on global item")

endmodule

bind midi_voice_allocator mva_checker u_mva_checker (.*);

`default_nettype wire

### tb/midi_voice_allocator_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// midi_voice_allocator_tb
// Drives MIDI messages and register writes into the voice allocator, keeps its
// own copy of the voice table to predict every voice command, and compares
// each command taken from the block against the oldest prediction.
// ----------------------------------------------------------------------------
`default_nettype none

import mva_pkg::*;

// voice table model plus the queue of predicted commands
class voice_scoreboard;
  bit          held [VOICES];
  bit          sustained [VOICES];
  bit          live [VOICES];
  logic [3:0]  chan_of [VOICES];
  logic [7:0]  note_of [VOICES];
  logic [6:0]  vel_of [VOICES];
  int unsigned rr_next;
  bit          pedal;
  bit          fallback;
  bit          mono, norm_vel, mpe_en, sync_en;
  logic [5:0]  shift;
  res_t        pending [$];
  res_t        burst [$];
  int          errors;

  function new();
    foreach (held[i]) begin
      held[i] = 0; sustained[i] = 0; live[i] = 0;
      chan_of[i] = '0; note_of[i] = '0; vel_of[i] = '0;
    end
    rr_next = 0; pedal = 0; fallback = 0;
    mono = 0; norm_vel = 0; mpe_en = 0; sync_en = 0; shift = '0;
    errors = 0;
  endfunction

  task report(string what);
    $display("[%0t] error: %s", $time, what);
    errors++;
  endtask

  function void set_reg(logic [2:0] idx, logic [5:0] data);
    case (idx)
      CFG_MONO:      mono = data[0];
      CFG_NORM_VEL:  norm_vel = data[0];
      CFG_MPE: begin
        mpe_en = data[0];
        fallback = 0;
      end
      CFG_TRANSPOSE: shift = data;
      CFG_OSC_SYNC:  sync_en = data[0];
      default: ;
    endcase
  endfunction

  function bit mpe_active();
    return mpe_en && !fallback;
  endfunction

  function logic [7:0] shifted(logic [6:0] pitch);
    return 8'({1'b0, pitch} + {{2{shift[5]}}, shift});
  endfunction

  // one command into the current burst, dropped past the result limit
  function void push(logic [3:0] cmd, int voice, int src, logic [7:0] note,
                     logic [6:0] vel, bit sync, logic [2:0] ctl, logic [13:0] val);
    res_t r;
    if (burst.size() >= MAX_RES) return;
    r.command = cmd; r.voice_index = 4'(voice); r.source_voice = 4'(src);
    r.note_number = note; r.velocity = vel; r.osc_sync = sync;
    r.controller_id = ctl; r.value = val; r.last = 0;
    burst.push_back(r);
  endfunction

  function void release_voice(int v);
    int top, target;
    held[v] = 0;
    if (mono) begin
      top = -1; target = 0;
      for (int i = 0; i < VOICES; i++)
        if (held[i] && int'(note_of[i]) > top) begin
          target = i;
          top = note_of[i];
        end
      if (top != -1 && live[v]) begin
        live[v] = 0;
        live[target] = 1;
        push(CMD_XFER_STATE, target, v, 0, 0, 0, 0, 0);
      end
    end
    if (pedal) sustained[v] = 1;
    else push(CMD_RELEASE, v, 0, 0, 0, 0, 0, 0);
  endfunction

  function void key_up(logic [3:0] ch, logic [6:0] pitch);
    logic [7:0] p;
    bit by_chan, hit;
    p = shifted(pitch);
    by_chan = mpe_active();
    for (int v = 0; v < VOICES; v++) begin
      hit = by_chan ? (chan_of[v] == ch) : (note_of[v] == p);
      if (hit && held[v]) begin
        release_voice(v);
        return;
      end
    end
  endfunction

  function void key_down(logic [3:0] ch, logic [6:0] pitch, logic [6:0] velo);
    logic [7:0] p;
    int v, found;
    if (velo == 0) begin
      key_up(ch, pitch);
      return;
    end
    p = shifted(pitch);
    if (norm_vel) velo = 7'((int'(velo) * int'(VEL_SCALE)) >> 16);
    if (mpe_active())
      for (int i = 0; i < VOICES; i++)
        if (held[i] && chan_of[i] == ch) fallback = 1;
    v = rr_next % VOICES;
    found = VOICES;
    for (int i = 0; i < VOICES; i++) begin
      if (!held[v]) begin
        found = v;
        break;
      end
      v = (v + 1) % VOICES;
    end
    if (found == VOICES) return;
    rr_next = (found + 1) % VOICES;
    chan_of[found] = ch;
    note_of[found] = p;
    vel_of[found] = velo;
    sustained[found] = pedal;
    held[found] = 1;
    push(CMD_START, found, 0, p, velo, sync_en, 0, 0);
    // mono handover from the sounding voice
    if (mono)
      for (int i = 0; i < VOICES; i++)
        if (live[i]) begin
          if (!held[i]) begin
            live[i] = 0;
            push(CMD_XFER_SIG, found, i, 0, 0, 0, 0, 0);
            break;
          end
          if (note_of[i] < p) begin
            live[i] = 0;
            push(CMD_XFER_STATE, found, i, 0, 0, 0, 0, 0);
            break;
          end
          return;
        end
    live[found] = 1;
  endfunction

  // accepted message: predict its commands
  function void note_msg(msg_t m);
    logic [3:0] ch, kind;
    logic [6:0] d1, d2;
    ch = m.status_byte[3:0];
    kind = m.status_byte[7:4];
    d1 = m.first_data;
    d2 = m.second_data;
    burst.delete();
    if (mpe_active() && ch != MPE_MASTER &&
        ((kind == REQ_CC && d1 == CC_TIMBRE) || kind == REQ_PRESSURE || kind == REQ_BEND)) begin
      // per-voice expression goes to the first voice on that channel
      for (int i = 0; i < VOICES; i++)
        if (held[i] && chan_of[i] == ch) begin
          if (kind == REQ_CC) push(CMD_TIMBRE, i, 0, 0, 0, 0, 0, 14'(d2));
          else if (kind == REQ_PRESSURE) push(CMD_PRESSURE, i, 0, 0, 0, 0, 0, 14'(d1));
          else push(CMD_VOICE_BEND, i, 0, 0, 0, 0, 0, {d2, d1});
          break;
        end
    end else begin
      case (kind)
        REQ_NOTE_OFF: key_up(ch, d1);
        REQ_NOTE_ON:  key_down(ch, d1, d2);
        REQ_CC: begin
          if (d1 == CC_MOD) push(CMD_CONTROLLER, 0, 0, 0, 0, 0, CTL_MOD, 14'(d2));
          else if (d1 == CC_BREATH) push(CMD_CONTROLLER, 0, 0, 0, 0, 0, CTL_BREATH, 14'(d2));
          else if (d1 == CC_FOOT) push(CMD_CONTROLLER, 0, 0, 0, 0, 0, CTL_FOOT, 14'(d2));
          else if (d1 == CC_SUSTAIN) begin
            pedal = d2 > PEDAL_THR;
            if (!pedal)
              for (int i = 0; i < VOICES; i++)
                if (sustained[i] && !held[i]) begin
                  push(CMD_RELEASE, i, 0, 0, 0, 0, 0, 0);
                  sustained[i] = 0;
                end
          end else if (d1 == CC_ALL_OFF) begin
            for (int i = 0; i < VOICES; i++)
              if (held[i]) release_voice(i);
          end
        end
        REQ_PROGRAM:
          push(CMD_PROGRAM, 0, 0, 0, 0, 0, 0, 14'(d1 > PROG_MAX ? PROG_MAX : d1));
        REQ_PRESSURE: push(CMD_CONTROLLER, 0, 0, 0, 0, 0, CTL_AFTERTOUCH, 14'(d1));
        REQ_BEND:     push(CMD_CONTROLLER, 0, 0, 0, 0, 0, CTL_BEND, {d2, d1});
        default: ;
      endcase
    end
    if (burst.size() > 0) burst[burst.size() - 1].last = 1;
    foreach (burst[i]) pending.push_back(burst[i]);
  endfunction

  // command taken from the block against the oldest prediction
  task check_res(res_t r);
    res_t e;
    if (pending.size() == 0) begin
      report($sformatf("command %0d voice %0d with nothing predicted",
                       r.command, r.voice_index));
      return;
    end
    e = pending.pop_front();
    if (r.command != e.command)
      report($sformatf("command %0d, predicted %0d", r.command, e.command));
    if (r.voice_index != e.voice_index)
      report($sformatf("voice_index %0d, predicted %0d", r.voice_index, e.voice_index));
    if (r.source_voice != e.source_voice)
      report($sformatf("source_voice %0d, predicted %0d", r.source_voice, e.source_voice));
    if (r.note_number != e.note_number)
      report($sformatf("note_number %0d, predicted %0d", r.note_number, e.note_number));
    if (r.velocity != e.velocity)
      report($sformatf("velocity %0d, predicted %0d", r.velocity, e.velocity));
    if (r.osc_sync != e.osc_sync)
      report($sformatf("osc_sync %0d, predicted %0d", r.osc_sync, e.osc_sync));
    if (r.controller_id != e.controller_id)
      report($sformatf("controller_id %0d, predicted %0d", r.controller_id, e.controller_id));
    if (r.value != e.value)
      report($sformatf("value %0d, predicted %0d", r.value, e.value));
    if (r.last != e.last)
      report($sformatf("last %0d, predicted %0d", r.last, e.last));
  endtask
endclass

module midi_voice_allocator_tb;
  localparam int DRAIN_CYCLES = 400;

  logic       clk;
  logic       rst;
  logic       msg_valid;
  logic       msg_ready;
  msg_t       msg;
  logic       res_valid;
  logic       res_ready;
  res_t       res;
  logic       cfg_valid;
  logic       cfg_ready;
  logic [2:0] cfg_index;
  logic [5:0] cfg_data;

  voice_scoreboard sb;
  int idle_mode;

  midi_voice_allocator DUT (
    .clk(clk), .rst(rst),
    .msg_valid(msg_valid), .msg_ready(msg_ready), .msg(msg),
    .res_valid(res_valid), .res_ready(res_ready), .res(res),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // command side: take and check, then pick the next ready
  always @(posedge clk) begin
    if (!rst && res_valid && res_ready) sb.check_res(res);
    case (idle_mode)
      2:       res_ready <= $urandom_range(99) >= 65;
      3:       res_ready <= $urandom_range(99) >= 20;
      default: res_ready <= 1'b1;
    endcase
  end

  // one message item, then in idle modes 1 and 3 a random gap for the sender
  task send(logic [7:0] st, logic [6:0] d1, logic [6:0] d2);
    msg_t m;
    m.status_byte = st;
    m.first_data = d1;
    m.second_data = d2;
    msg_valid <= 1'b1;
    msg <= m;
    do @(posedge clk); while (!msg_ready);
    sb.note_msg(m);
    if ((idle_mode == 1 && $urandom_range(99) < 65) ||
        (idle_mode == 3 && $urandom_range(99) < 20)) begin
      msg_valid <= 1'b0;
      do @(posedge clk);
      while ((idle_mode == 1 && $urandom_range(99) < 65) ||
             (idle_mode == 3 && $urandom_range(99) < 20));
    end
  endtask

  task write_reg(logic [2:0] idx, logic [5:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    sb.set_reg(idx, data);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // hold the sender until every predicted command is out, then let the block go quiet
  task drain;
    int waited;
    msg_valid <= 1'b0;
    waited = 0;
    while (sb.pending.size() != 0 && waited < 200000) begin
      @(posedge clk);
      waited++;
    end
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  function logic [6:0] pick_pitch();
    return ($urandom_range(99) < 80) ? 7'($urandom_range(60, 67)) : 7'($urandom_range(127));
  endfunction

  // mostly well-formed traffic around a small set of notes and channels
  task send_random;
    logic [3:0] ch;
    int roll;
    logic [6:0] cc_pick [7];
    cc_pick = '{CC_MOD, CC_BREATH, CC_FOOT, CC_SUSTAIN, CC_TIMBRE, CC_ALL_OFF, 7'd7};
    ch = ($urandom_range(99) < 85) ? 4'($urandom_range(3)) : 4'($urandom_range(15));
    roll = $urandom_range(99);
    if (roll < 36)
      send({REQ_NOTE_ON, ch}, pick_pitch(),
           ($urandom_range(9) == 0) ? 7'd0 : 7'($urandom_range(1, 127)));
    else if (roll < 62)
      send({REQ_NOTE_OFF, ch}, pick_pitch(), 7'($urandom_range(127)));
    else if (roll < 78) begin
      if ($urandom_range(19) == 0)
        send({REQ_CC, ch}, CC_ALL_OFF, 7'($urandom_range(127)));
      else
        send({REQ_CC, ch}, cc_pick[$urandom_range(4)], 7'($urandom_range(127)));
    end else if (roll < 83)
      send({REQ_PROGRAM, ch}, 7'($urandom_range(127)), 7'($urandom_range(127)));
    else if (roll < 89)
      send({REQ_PRESSURE, ch}, 7'($urandom_range(127)), 7'($urandom_range(127)));
    else if (roll < 95)
      send({REQ_BEND, ch}, 7'($urandom_range(127)), 7'($urandom_range(127)));
    else
      send(8'($urandom_range(255)), 7'($urandom_range(127)), 7'($urandom_range(127)));
  endtask

  initial begin
    int mono_s [8], norm_s [8], mpe_s [8], sync_s [8], shift_s [8];
    mono_s  = '{0, 1, 0, 1, 0, 1, 1, 0};
    norm_s  = '{1, 0, 0, 1, 1, 0, 1, 0};
    mpe_s   = '{0, 0, 1, 1, 0, 1, 0, 1};
    sync_s  = '{1, 0, 1, 0, 1, 1, 0, 0};
    shift_s = '{-24, 24, 0, 7, -5, -24, 24, 0};
    sb = new();
    idle_mode = 0;
    rst = 1'b1;
    msg_valid <= 1'b0;
    msg <= '0;
    res_ready <= 1'b0;
    cfg_valid <= 1'b0;
    cfg_index <= '0;
    cfg_data <= '0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: single commands, ignored messages, pedal and a full table
    send({REQ_PROGRAM, 4'd0}, 7'd0, 7'd0);
    send({REQ_PROGRAM, 4'd15}, 7'd127, 7'd127);
    send({REQ_CC, 4'd3}, CC_MOD, 7'd127);
    send({REQ_CC, 4'd3}, CC_BREATH, 7'd0);
    send({REQ_CC, 4'd3}, CC_FOOT, 7'd64);
    send({REQ_PRESSURE, 4'd2}, 7'd127, 7'd0);
    send({REQ_BEND, 4'd2}, 7'd127, 7'd127);
    send(8'h00, 7'd5, 7'd5);
    send(8'hA5, 7'd60, 7'd100);
    send(8'hFF, 7'd127, 7'd127);
    send({REQ_NOTE_OFF, 4'd0}, 7'd60, 7'd0);
    send({REQ_NOTE_ON, 4'd0}, 7'd0, 7'd127);
    send({REQ_NOTE_ON, 4'd0}, 7'd127, 7'd1);
    send({REQ_NOTE_ON, 4'd0}, 7'd127, 7'd0);
    send({REQ_CC, 4'd0}, CC_SUSTAIN, 7'd127);
    send({REQ_NOTE_OFF, 4'd0}, 7'd0, 7'd0);
    send({REQ_CC, 4'd0}, CC_SUSTAIN, 7'd0);
    for (int i = 0; i < 17; i++) send({REQ_NOTE_ON, 4'(i)}, 7'(40 + i), 7'd90);
    send({REQ_CC, 4'd0}, CC_ALL_OFF, 7'd0);
    drain();

    // register settings, each followed by random traffic under one idling style
    for (int ph = 0; ph < 8; ph++) begin
      write_reg(CFG_MONO, 6'(mono_s[ph]));
      write_reg(CFG_NORM_VEL, 6'(norm_s[ph]));
      write_reg(CFG_MPE, 6'(mpe_s[ph]));
      write_reg(CFG_TRANSPOSE, 6'(shift_s[ph]));
      write_reg(CFG_OSC_SYNC, 6'(sync_s[ph]));
      idle_mode = ph % 4;
      for (int n = 0; n < 48; n++) send_random();
      drain();
    end

    if (sb.pending.size() != 0)
      sb.report($sformatf("%0d predicted commands never came", sb.pending.size()));
    if (sb.errors == 0) $display("SCOREBOARD CLEAN");
    else $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin
    #10_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end
endmodule

`default_nettype wire
